FILE: rtl/sul_pkg.sv
// shared types and codes for the sorted unique character list
package sul_pkg;

  // operation codes carried in func
  localparam logic [1:0] OP_INSERT   = 2'd0;
  localparam logic [1:0] OP_DELETE   = 2'd1;
  localparam logic [1:0] OP_TRAVERSE = 2'd2;

  // result status codes
  localparam logic [3:0] ST_INS_EMPTY = 4'd0;
  localparam logic [3:0] ST_INS_FRONT = 4'd1;
  localparam logic [3:0] ST_INS_MID   = 4'd2;
  localparam logic [3:0] ST_INS_END   = 4'd3;
  localparam logic [3:0] ST_DUP       = 4'd4;
  localparam logic [3:0] ST_FULL      = 4'd5;
  localparam logic [3:0] ST_DEL_FRONT = 4'd6;
  localparam logic [3:0] ST_DEL_REST  = 4'd7;
  localparam logic [3:0] ST_ABSENT    = 4'd8;
  localparam logic [3:0] ST_EMPTY     = 4'd9;
  localparam logic [3:0] ST_ITEM      = 4'd10;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_INS_SH_RD,
    S_INS_SH_WR,
    S_INS_PUT,
    S_DEL_SH_RD,
    S_DEL_SH_WR,
    S_TRAV_RD,
    S_TRAV_OUT,
    S_REPORT
  } state_t;

endpackage

FILE: rtl/sul_ram.sv
// generic single write port ram with registered read
module sul_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/sorted_unique_char_list_core.sv
// top level: ascending list of distinct signed bytes with insert, delete, traverse
// steps: an empty list is settled at accept; otherwise entries are read and compared
//   in order, then insert shifts later entries up and writes the value, delete shifts
//   later entries down; duplicate/full/absent skip the shift; a stall holds traverse
// throughput: one transaction at a time, ready the cycle after its last result loads
// reset: rst (synchronous) empties the list; ram contents are not cleared
module sorted_unique_char_list_core #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [1:0] func, [9:2] value, rest zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [3:0] status, [11:4] item, rest zero
  output logic        m_tlast
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE = CW'(1);

  sul_pkg::state_t state, state_next;

  logic [1:0]        op;
  logic signed [7:0] val;
  logic [CW-1:0]     idx, idx_next;
  logic [CW-1:0]     pos, pos_next;
  logic [CW-1:0]     count, count_next;
  logic [3:0]        status, status_next;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [7:0]        ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [7:0]        ram_rdata;
  logic signed [7:0] rd_val;

  logic              accept;
  logic [1:0]        in_func;
  logic signed [7:0] in_value;
  logic              out_free;
  logic              out_load;
  logic [3:0]        out_status;
  logic [7:0]        out_item;
  logic              out_last;
  logic              idx_is_last;

  assign in_func     = s_tdata[1:0];
  assign in_value    = s_tdata[9:2];
  assign s_tready    = (state == sul_pkg::S_IDLE);
  assign accept      = s_tvalid && s_tready;
  assign out_free    = !m_tvalid || m_tready;
  assign rd_val      = ram_rdata;
  assign idx_is_last = ((idx + ONE) == count);

  // entry storage
  sul_ram #(
    .WIDTH (8),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // read address follows the sequencer step
  always_comb begin
    case (state)
      sul_pkg::S_INS_SH_RD, sul_pkg::S_INS_SH_WR: ram_raddr = AW'(idx - ONE);
      sul_pkg::S_DEL_SH_RD, sul_pkg::S_DEL_SH_WR: ram_raddr = AW'(idx + ONE);
      default:                                    ram_raddr = AW'(idx);
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      sul_pkg::S_IDLE: begin
        if (accept) begin
          case (in_func)
            sul_pkg::OP_INSERT:   state_next = (count == '0) ? sul_pkg::S_REPORT
                                                             : sul_pkg::S_SCAN_RD;
            sul_pkg::OP_DELETE:   state_next = (count == '0) ? sul_pkg::S_REPORT
                                                             : sul_pkg::S_SCAN_RD;
            sul_pkg::OP_TRAVERSE: state_next = (count == '0) ? sul_pkg::S_REPORT
                                                             : sul_pkg::S_TRAV_RD;
            default:              state_next = sul_pkg::S_IDLE;
          endcase
        end
      end
      sul_pkg::S_SCAN_RD: state_next = sul_pkg::S_SCAN_CMP;
      sul_pkg::S_SCAN_CMP: begin
        if (op == sul_pkg::OP_INSERT) begin
          if (rd_val < val) begin
            if (idx_is_last) begin
              state_next = (count >= CAP) ? sul_pkg::S_REPORT : sul_pkg::S_INS_SH_RD;
            end else begin
              state_next = sul_pkg::S_SCAN_RD;
            end
          end else if (rd_val == val) begin
            state_next = sul_pkg::S_REPORT;
          end else begin
            state_next = (count >= CAP) ? sul_pkg::S_REPORT : sul_pkg::S_INS_SH_RD;
          end
        end else begin
          if (rd_val == val) begin
            state_next = sul_pkg::S_DEL_SH_RD;
          end else if (idx_is_last) begin
            state_next = sul_pkg::S_REPORT;
          end else begin
            state_next = sul_pkg::S_SCAN_RD;
          end
        end
      end
      sul_pkg::S_INS_SH_RD: begin
        state_next = (idx == pos) ? sul_pkg::S_INS_PUT : sul_pkg::S_INS_SH_WR;
      end
      sul_pkg::S_INS_SH_WR: state_next = sul_pkg::S_INS_SH_RD;
      sul_pkg::S_INS_PUT:   state_next = sul_pkg::S_REPORT;
      sul_pkg::S_DEL_SH_RD: begin
        state_next = ((idx + ONE) >= count) ? sul_pkg::S_REPORT : sul_pkg::S_DEL_SH_WR;
      end
      sul_pkg::S_DEL_SH_WR: state_next = sul_pkg::S_DEL_SH_RD;
      sul_pkg::S_TRAV_RD:   state_next = sul_pkg::S_TRAV_OUT;
      sul_pkg::S_TRAV_OUT: begin
        if (out_free) begin
          state_next = idx_is_last ? sul_pkg::S_IDLE : sul_pkg::S_TRAV_RD;
        end
      end
      sul_pkg::S_REPORT: begin
        if (out_free) begin
          state_next = sul_pkg::S_IDLE;
        end
      end
      default: state_next = sul_pkg::S_IDLE;
    endcase
  end

  // datapath controls and result selection
  always_comb begin
    idx_next    = idx;
    pos_next    = pos;
    count_next  = count;
    status_next = status;
    ram_we      = 1'b0;
    ram_waddr   = AW'(idx);
    ram_wdata   = ram_rdata;
    out_load    = 1'b0;
    out_status  = status;
    out_item    = '0;
    out_last    = 1'b1;
    case (state)
      sul_pkg::S_IDLE: begin
        idx_next = '0;
        if (accept && count == '0) begin
          if (in_func == sul_pkg::OP_INSERT) begin
            ram_we      = 1'b1;
            ram_waddr   = '0;
            ram_wdata   = in_value;
            count_next  = ONE;
            status_next = sul_pkg::ST_INS_EMPTY;
          end else begin
            status_next = sul_pkg::ST_EMPTY;
          end
        end
      end
      sul_pkg::S_SCAN_CMP: begin
        if (op == sul_pkg::OP_INSERT) begin
          if (rd_val < val) begin
            if (idx_is_last) begin
              pos_next    = count;
              idx_next    = count;
              status_next = sul_pkg::ST_FULL;
            end else begin
              idx_next = idx + ONE;
            end
          end else if (rd_val == val) begin
            status_next = sul_pkg::ST_DUP;
          end else begin
            pos_next    = idx;
            idx_next    = count;
            status_next = sul_pkg::ST_FULL;
          end
        end else begin
          if (rd_val == val) begin
            pos_next = idx;
          end else if (idx_is_last) begin
            status_next = sul_pkg::ST_ABSENT;
          end else begin
            idx_next = idx + ONE;
          end
        end
      end
      // move one entry up by one place
      sul_pkg::S_INS_SH_WR: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(idx);
        idx_next  = idx - ONE;
      end
      sul_pkg::S_INS_PUT: begin
        ram_we     = 1'b1;
        ram_waddr  = AW'(pos);
        ram_wdata  = val;
        count_next = count + ONE;
        if (pos == '0) begin
          status_next = sul_pkg::ST_INS_FRONT;
        end else if (pos == count) begin
          status_next = sul_pkg::ST_INS_END;
        end else begin
          status_next = sul_pkg::ST_INS_MID;
        end
      end
      // close the gap left by a removed entry
      sul_pkg::S_DEL_SH_RD: begin
        if ((idx + ONE) >= count) begin
          count_next  = count - ONE;
          status_next = (pos == '0) ? sul_pkg::ST_DEL_FRONT : sul_pkg::ST_DEL_REST;
        end
      end
      sul_pkg::S_DEL_SH_WR: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(idx);
        idx_next  = idx + ONE;
      end
      sul_pkg::S_TRAV_OUT: begin
        out_load   = out_free;
        out_status = sul_pkg::ST_ITEM;
        out_item   = ram_rdata;
        out_last   = idx_is_last;
        if (out_free) begin
          idx_next = idx + ONE;
        end
      end
      sul_pkg::S_REPORT: begin
        out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sul_pkg::S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op  <= in_func;
      val <= in_value;
    end
    idx    <= idx_next;
    pos    <= pos_next;
    status <= status_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {4'b0, out_item, out_status};
      m_tlast <= out_last;
    end
  end

  // list never grows past its capacity
  assert property (@(posedge clk) disable iff (rst) count <= CAP)
    else $error("fill count above capacity");

  // placing a new entry grows the list by one
  assert property (@(posedge clk) disable iff (rst)
    state == sul_pkg::S_INS_PUT |=> count == $past(count) + ONE)
    else $error("insert did not grow the list");

  // every non-item result is the single, final one of its transaction
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[3:0] != sul_pkg::ST_ITEM |-> m_tlast)
    else $error("single result without last");

  // traverse of a non-empty list starts reading entries
  assert property (@(posedge clk) disable iff (rst)
    accept && in_func == sul_pkg::OP_TRAVERSE && count != '0
      |=> state == sul_pkg::S_TRAV_RD)
    else $error("traverse did not start");

endmodule
